FILE: hw/rtl/r2n_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2n_pkg: shared types and constants
// Frame size limits, field widths, color coefficients and the structs that
// travel between the parts of the RGB888 to NV21 converter.
// ----------------------------------------------------------------------------
package r2n_pkg;

  // Largest frame the position logic and address arithmetic support.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int SIZE_W    = 13;  // width of a frame size register
  localparam int POS_W     = 12;  // width of a column or row position
  localparam int LADDR_W   = 24;
  localparam int CADDR_W   = 25;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] MAX_WIDTH_S  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_S = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(512);

  // BT.601 style integer coefficients.
  localparam logic [7:0] Y_R = 8'd74;
  localparam logic [7:0] Y_G = 8'd150;
  localparam logic [7:0] Y_B = 8'd29;
  localparam logic [7:0] U_R = 8'd43;   // subtracted
  localparam logic [7:0] U_G = 8'd84;   // subtracted
  localparam logic [7:0] U_B = 8'd112;
  localparam logic [7:0] V_R = 8'd128;
  localparam logic [7:0] V_G = 8'd107;  // subtracted
  localparam logic [7:0] V_B = 8'd21;   // subtracted
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Placement of one pixel in the flipped NV21 frame.
  typedef struct packed {
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  frow;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              done;
  } position_t;

endpackage

FILE: hw/rtl/r2n_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2n_pixel_if: input pixel channel
// Valid/ready channel carrying one BGR888 pixel per item.
// ----------------------------------------------------------------------------
interface r2n_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

FILE: hw/rtl/r2n_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2n_result_if: output result channel
// Valid/ready channel carrying the luma and chroma writes for one pixel.
// ----------------------------------------------------------------------------
interface r2n_result_if;
  logic        valid;
  logic        ready;
  logic [23:0] luma_address;
  logic [7:0]  luma;
  logic [24:0] chroma_address;
  logic [7:0]  v_value;
  logic [7:0]  u_value;
  logic        frame_done;

  modport source (output valid, output luma_address, output luma, output chroma_address,
                  output v_value, output u_value, output frame_done, input ready);
  modport sink   (input valid, input luma_address, input luma, input chroma_address,
                  input v_value, input u_value, input frame_done, output ready);
endinterface

FILE: hw/rtl/r2n_position_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2n_position_tracker: frame size registers and raster counters
// Holds the size registers, saturates them, and tracks column and row.
// ----------------------------------------------------------------------------
module r2n_position_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [r2n_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [r2n_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                               accept,
  output r2n_pkg::position_t                 position
);

  logic [r2n_pkg::SIZE_W-1:0] frame_width;
  logic [r2n_pkg::SIZE_W-1:0] frame_height;
  logic [r2n_pkg::POS_W-1:0]  column_count;
  logic [r2n_pkg::POS_W-1:0]  input_row_count;
  logic [r2n_pkg::POS_W-1:0]  column_count_next;
  logic [r2n_pkg::POS_W-1:0]  input_row_count_next;

  logic [r2n_pkg::SIZE_W-1:0] w_eff;
  logic [r2n_pkg::SIZE_W-1:0] h_eff;
  logic [r2n_pkg::POS_W-1:0]  col;
  logic [r2n_pkg::POS_W-1:0]  row;
  logic                       last_col;
  logic                       last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= r2n_pkg::SIZE_RESET;
      frame_height <= r2n_pkg::SIZE_RESET;
    end else if (cfg_wen) begin
      unique case (r2n_pkg::cfg_index_t'(cfg_index))
        r2n_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        r2n_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) w_eff = r2n_pkg::SIZE_W'(1);
    else if (frame_width > r2n_pkg::MAX_WIDTH_S) w_eff = r2n_pkg::MAX_WIDTH_S;
    else w_eff = frame_width;

    if (frame_height == '0) h_eff = r2n_pkg::SIZE_W'(1);
    else if (frame_height > r2n_pkg::MAX_HEIGHT_S) h_eff = r2n_pkg::MAX_HEIGHT_S;
    else h_eff = frame_height;

    // Counters left beyond a shrunken frame restart at zero.
    col = ({1'b0, column_count} >= w_eff) ? '0 : column_count;
    row = ({1'b0, input_row_count} >= h_eff) ? '0 : input_row_count;

    last_col = ({1'b0, col} + r2n_pkg::SIZE_W'(1)) == w_eff;
    last_row = ({1'b0, row} + r2n_pkg::SIZE_W'(1)) == h_eff;

    if (last_col) begin
      column_count_next    = '0;
      input_row_count_next = last_row ? '0 : row + r2n_pkg::POS_W'(1);
    end else begin
      column_count_next    = col + r2n_pkg::POS_W'(1);
      input_row_count_next = row;
    end

    position.col    = col;
    position.frow   = r2n_pkg::POS_W'(h_eff - r2n_pkg::SIZE_W'(1) - {1'b0, row});
    position.width  = w_eff;
    position.height = h_eff;
    position.done   = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      input_row_count <= '0;
    end else if (accept) begin
      column_count    <= column_count_next;
      input_row_count <= input_row_count_next;
    end
  end

endmodule

FILE: hw/rtl/r2n_color_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2n_color_convert: RGB to YUV datapath
// Dot products, luma >> 8, chroma / 255 with offset and clamp, then the result register.
// ----------------------------------------------------------------------------
module r2n_color_convert (
  input  logic            clk,
  input  logic            load,
  input  r2n_pkg::pixel_t pixel,
  output logic [7:0]      luma,
  output logic [7:0]      v_value,
  output logic [7:0]      u_value
);

  logic [15:0]        y_sum;
  logic signed [16:0] u_num;
  logic signed [16:0] v_num;
  logic [7:0]         v_byte;
  logic [7:0]         u_byte;

  // Signed value divided by 255 with truncation toward zero, plus 128, clamped.
  function automatic logic [7:0] chroma_byte(input logic signed [16:0] num);
    logic [15:0]       mag;
    logic [15:0]       sum;
    logic [7:0]        quo;
    logic signed [9:0] res;
    mag = num[16] ? 16'(-num) : num[15:0];
    // Exact floor(mag / 255) for mag below 65280, where the 16-bit sum cannot overflow.
    sum = mag + 16'd1 + {8'd0, mag[15:8]};
    quo = sum[15:8];
    res = num[16] ? (10'sd128 - $signed({2'b00, quo}))
                  : (10'sd128 + $signed({2'b00, quo}));
    if (res < 10'sd0) chroma_byte = 8'd0;
    else if (res > 10'sd255) chroma_byte = 8'd255;
    else chroma_byte = res[7:0];
  endfunction

  always_comb begin
    y_sum = 16'(pixel.red * r2n_pkg::Y_R) + 16'(pixel.green * r2n_pkg::Y_G)
          + 16'(pixel.blue * r2n_pkg::Y_B);
    u_num = $signed({1'b0, 16'(pixel.blue * r2n_pkg::U_B)})
          - $signed({1'b0, 16'(pixel.red * r2n_pkg::U_R)})
          - $signed({1'b0, 16'(pixel.green * r2n_pkg::U_G)});
    v_num = $signed({1'b0, 16'(pixel.red * r2n_pkg::V_R)})
          - $signed({1'b0, 16'(pixel.green * r2n_pkg::V_G)})
          - $signed({1'b0, 16'(pixel.blue * r2n_pkg::V_B)});
    v_byte = chroma_byte(v_num);
    u_byte = chroma_byte(u_num);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      luma    <= y_sum[15:8];  // at most 252, never needs a clamp
      v_value <= v_byte;
      u_value <= u_byte;
    end
  end

endmodule

FILE: hw/rtl/r2n_address_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2n_address_gen: NV21 address datapath
// Row products and column offsets ahead of the result register.
// ----------------------------------------------------------------------------
module r2n_address_gen (
  input  logic                                clk,
  input  logic                                load,
  input  r2n_pkg::position_t                  position,
  output logic [r2n_pkg::LADDR_W-1:0]         luma_address,
  output logic [r2n_pkg::CADDR_W-1:0]         chroma_address,
  output logic                                frame_done
);

  logic [r2n_pkg::LADDR_W-1:0] luma_row_base;
  logic [r2n_pkg::CADDR_W-1:0] chroma_row_base;
  logic [r2n_pkg::SIZE_W-1:0]  chroma_row;

  // The chroma plane starts after H rows of luma, so its row index is H + frow/2.
  assign chroma_row = position.height + r2n_pkg::SIZE_W'(position.frow[r2n_pkg::POS_W-1:1]);

  assign luma_row_base   = r2n_pkg::LADDR_W'(position.frow * position.width);
  assign chroma_row_base = r2n_pkg::CADDR_W'(chroma_row * position.width);

  always_ff @(posedge clk) begin
    if (load) begin
      luma_address   <= luma_row_base + r2n_pkg::LADDR_W'(position.col);
      chroma_address <= chroma_row_base
                      + r2n_pkg::CADDR_W'({position.col[r2n_pkg::POS_W-1:1], 1'b0});
      frame_done     <= position.done;
    end
  end

endmodule

FILE: hw/rtl/rgb888_to_nv21_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb888_to_nv21_converter_unit: streaming BGR888 to NV21 converter
// Converts raster-order pixels to YUV and gives their NV21 byte addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels arrive on the pixel channel, one BGR triple per item, in raster
//   order. Each item yields exactly one item on the result channel holding the
//   luma address and value and the V/U pair with the address of its V byte
//   (U sits at the next byte). Rows are flipped vertically in the frame.
//   frame_done marks the last pixel of a frame; the counters then wrap.
//   The user must write frame_width and frame_height through the cfg port while
//   the block is idle; it does not enforce this. Sizes outside 1..4096 saturate.
// Timing:
//   Two register stages: the input register holds the pixel and its
//   placement, and all arithmetic sits between it and the result register.
//   A result is offered once its pixel has moved from the input register
//   into the result register. It sustains one item per clock while result.ready
//   is high. The position counters set the rate; they step once per accepted item.
// Reset:
//   rst clears both valid bits and the counters, and loads 512 into both
//   size registers.
// Back-pressure:
//   The input register holds its item while the result waits on ready; with
//   both registers full, pixel.ready drops in the same cycle as result.ready.
// ----------------------------------------------------------------------------
module rgb888_to_nv21_converter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [r2n_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [r2n_pkg::SIZE_W-1:0]     cfg_data,
  r2n_pixel_if.sink                      pixel,
  r2n_result_if.source                   result
);

  // Valid bits of the input register and the result register.
  logic stage1_valid;
  logic result_valid;

  logic accept;
  logic load_result;
  logic stage1_free;
  logic result_free;

  r2n_pkg::position_t position_in;
  r2n_pkg::position_t position;   // input register: pixel placement
  r2n_pkg::pixel_t    pixel_reg;  // input register: pixel color

  // Ready ripples back from the output: a register can load when it is empty
  // or when its own item moves on in the same cycle.
  always_comb begin
    result_free = !result_valid || result.ready;
    stage1_free = !stage1_valid || result_free;
    load_result = stage1_valid && result_free;
    accept      = pixel.valid && stage1_free;
  end

  assign pixel.ready  = stage1_free;
  assign result.valid = result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (stage1_free) stage1_valid <= pixel.valid;
      if (result_free) result_valid <= stage1_valid;
    end
  end

  // The position is captured with the pixel, so the result logic never looks
  // back at the counters or the size registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      position        <= position_in;
      pixel_reg.blue  <= pixel.blue;
      pixel_reg.green <= pixel.green;
      pixel_reg.red   <= pixel.red;
    end
  end

  r2n_position_tracker u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .position  (position_in)
  );

  r2n_color_convert u_color (
    .clk     (clk),
    .load    (load_result),
    .pixel   (pixel_reg),
    .luma    (result.luma),
    .v_value (result.v_value),
    .u_value (result.u_value)
  );

  r2n_address_gen u_address (
    .clk            (clk),
    .load           (load_result),
    .position       (position),
    .luma_address   (result.luma_address),
    .chroma_address (result.chroma_address),
    .frame_done     (result.frame_done)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB888 to NV21 converter
// Streams BGR pixels into the converter under several frame sizes. The bench
// keeps its own copy of the frame size registers and the position counters,
// works out the NV21 luma and chroma writes for every accepted pixel, and
// compares each result item field by field with the oldest expected write.
// Both sides of the stream idle at random, and the result side also holds
// off for a long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

  // The receiver holds off this many cycles once, while the sender keeps
  // offering pixels, so that every stage of the pipeline ends up full.
  localparam int HOLD_CYCLES = 300;

  // Rough number of pixels in the randomized frames.
  localparam int RANDOM_ITEMS = 900;

  // The block has two register stages; a few more cycles after the last
  // result give any stray result the chance to show up.
  localparam int DRAIN_CYCLES = 8;

  // The run, with the hold and the drains, ends far below this limit even
  // in its slowest case.
  localparam longint LIMIT_CYCLES = 200000;

  // One expected NV21 write: the luma byte and the V/U pair of its block.
  typedef struct packed {
    logic [r2n_pkg::LADDR_W-1:0] luma_address;
    logic [7:0]                  luma;
    logic [r2n_pkg::CADDR_W-1:0] chroma_address;
    logic [7:0]                  v_value;
    logic [7:0]                  u_value;
    logic                        frame_done;
  } nv21_write_t;

  // Directed colors, listed as blue, green, red. Pure red drives V past
  // 255 before the clamp; a red of one gives a small negative U product,
  // which must truncate toward zero rather than round down.
  localparam r2n_pkg::pixel_t DIRECTED_COLORS [8] = '{
    '{8'h00, 8'h00, 8'h00},
    '{8'hff, 8'hff, 8'hff},
    '{8'h00, 8'h00, 8'hff},
    '{8'h00, 8'hff, 8'h00},
    '{8'hff, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h01},
    '{8'haa, 8'h55, 8'haa},
    '{8'h55, 8'haa, 8'h55}
  };

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wen;
  r2n_pkg::cfg_index_t        cfg_index;
  logic [r2n_pkg::SIZE_W-1:0] cfg_data;

  r2n_pixel_if  pixel_ch ();
  r2n_result_if result_ch ();

  rgb888_to_nv21_converter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  // Bench copy of the size registers and the position counters. The
  // counters hold the column and the input row of the next pixel.
  logic [r2n_pkg::SIZE_W-1:0] width_reg  = r2n_pkg::SIZE_RESET;
  logic [r2n_pkg::SIZE_W-1:0] height_reg = r2n_pkg::SIZE_RESET;
  longint                     col_pos    = 0;
  longint                     row_pos    = 0;

  // Writes predicted for accepted pixels, oldest first.
  nv21_write_t nv21_write_q [$];

  bit     send_idle_en  = 1'b0;
  bit     recv_idle_en  = 1'b0;
  bit     sink_hold_req = 1'b0;
  int     error_count   = 0;
  int     checked_count = 0;
  int     frame_count   = 0;
  int     setting_count = 0;
  longint cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Size registers outside 1..max are used saturated into that range.
  function automatic longint clip_size(logic [r2n_pkg::SIZE_W-1:0] value, longint maxv);
    if (value == 0) return 1;
    if (value > maxv) return maxv;
    return value;
  endfunction

  function automatic logic [7:0] clamp_byte(int value);
    if (value < 0) return 8'd0;
    if (value > 255) return 8'd255;
    return value[7:0];
  endfunction

  // Works out the NV21 write for one accepted pixel and moves the counters.
  function automatic nv21_write_t predict_nv21_write(r2n_pkg::pixel_t px);
    longint      w, h, col, row, frow, laddr, caddr;
    int          r, g, b, y, u, v;
    nv21_write_t wr;
    w = clip_size(width_reg, r2n_pkg::MAX_WIDTH);
    h = clip_size(height_reg, r2n_pkg::MAX_HEIGHT);
    // After a size change mid-frame a counter may sit beyond the new size.
    // Such a counter restarts at zero.
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    r = px.red;
    g = px.green;
    b = px.blue;
    // Signed integer division truncates toward zero, as the block must.
    y = (74 * r + 150 * g + 29 * b) >>> 8;
    u = (112 * b - 43 * r - 84 * g) / 255 + 128;
    v = (128 * r - 107 * g - 21 * b) / 255 + 128;
    // Rows are stored bottom up; the chroma plane follows the luma plane.
    frow  = h - 1 - row;
    laddr = frow * w + col;
    caddr = h * w + (frow / 2) * w + (col / 2) * 2;
    wr.luma_address   = laddr[r2n_pkg::LADDR_W-1:0];
    wr.luma           = clamp_byte(y);
    wr.chroma_address = caddr[r2n_pkg::CADDR_W-1:0];
    wr.v_value        = clamp_byte(v);
    wr.u_value        = clamp_byte(u);
    wr.frame_done     = (col + 1 == w) && (row + 1 == h);
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    if (wr.frame_done) frame_count++;
    return wr;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void compare_field(string field, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, actual %0d", field, expv, actv);
      error_count++;
    end
  endfunction

  // Called at the edge where a result item is accepted; the outputs still
  // hold their values from before the edge.
  task automatic check_nv21_write();
    nv21_write_t wr;
    if (nv21_write_q.size() == 0) begin
      $error("result item with no pixel outstanding: luma_address %0d",
             result_ch.luma_address);
      error_count++;
      return;
    end
    wr = nv21_write_q.pop_front();
    compare_field("luma_address", 32'(wr.luma_address), 32'(result_ch.luma_address));
    compare_field("luma", 32'(wr.luma), 32'(result_ch.luma));
    compare_field("chroma_address", 32'(wr.chroma_address),
                  32'(result_ch.chroma_address));
    compare_field("v_value", 32'(wr.v_value), 32'(result_ch.v_value));
    compare_field("u_value", 32'(wr.u_value), 32'(result_ch.u_value));
    compare_field("frame_done", 32'(wr.frame_done), 32'(result_ch.frame_done));
    checked_count++;
  endtask

  // Result side. Ready stays high across items unless a stall is drawn, so
  // it never gets two assignments in one time step.
  initial begin : result_sink
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = recv_idle_en ? $urandom_range(5, 0) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      check_nv21_write();
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $error("run did not finish within %0d cycles, %0d writes still expected",
             LIMIT_CYCLES, nv21_write_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic r2n_pkg::pixel_t random_pixel();
    r2n_pkg::pixel_t px;
    px = r2n_pkg::pixel_t'(24'($urandom()));
    // Now and then push the components to their extremes.
    if ($urandom_range(7, 0) == 0) begin
      px.blue  = $urandom_range(1, 0) ? 8'hff : 8'h00;
      px.green = $urandom_range(1, 0) ? 8'hff : 8'h00;
      px.red   = $urandom_range(1, 0) ? 8'hff : 8'h00;
    end
    return px;
  endfunction

  // Offers one pixel and waits until it is accepted. Valid is only lowered
  // when a gap is drawn, so back-to-back items keep it high.
  task automatic send_pixel(r2n_pkg::pixel_t px);
    int gap;
    gap = send_idle_en ? $urandom_range(5, 0) : 0;
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.blue  <= px.blue;
    pixel_ch.green <= px.green;
    pixel_ch.red   <= px.red;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    nv21_write_q.push_back(predict_nv21_write(px));
  endtask

  task automatic send_random_pixels(int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Stops the stream and waits until every expected write has come back,
  // leaving the block idle.
  task automatic wait_for_drain();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (nv21_write_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size_reg(r2n_pkg::cfg_index_t idx,
                                logic [r2n_pkg::SIZE_W-1:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == r2n_pkg::REG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // Only called on an idle block, after wait_for_drain.
  task automatic set_frame_size(int w, int h);
    write_size_reg(r2n_pkg::REG_FRAME_WIDTH, r2n_pkg::SIZE_W'(w));
    write_size_reg(r2n_pkg::REG_FRAME_HEIGHT, r2n_pkg::SIZE_W'(h));
    setting_count++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The first pixels after reset land at the bottom row of a 512 by 512
  // frame, which shows the size registers came out of reset correctly.
  task automatic test_reset_size();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    send_pixel(DIRECTED_COLORS[1]);
    send_pixel(DIRECTED_COLORS[0]);
  endtask

  // Color extremes in a tiny frame, which also wraps at frame end.
  task automatic test_color_extremes();
    wait_for_drain();
    set_frame_size(4, 2);
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    foreach (DIRECTED_COLORS[i]) send_pixel(DIRECTED_COLORS[i]);
  endtask

  // Sizes of zero and above the maximum saturate; the full 4096 by 4096
  // frame puts the addresses near the top of their ranges.
  task automatic test_size_saturation();
    wait_for_drain();
    set_frame_size(0, 8191);
    send_random_pixels(2);
    wait_for_drain();
    set_frame_size(8191, 0);
    send_random_pixels(2);
    wait_for_drain();
    set_frame_size(4096, 4096);
    send_random_pixels(2);
  endtask

  // Shrinking the frame mid-way leaves both counters past the new size.
  task automatic test_resize_mid_frame();
    wait_for_drain();
    set_frame_size(4, 4);
    send_random_pixels(7);
    wait_for_drain();
    set_frame_size(2, 1);
    send_random_pixels(3);
  endtask

  // The receiver stops for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    wait_for_drain();
    set_frame_size(5, 3);
    send_idle_en  = 1'b0;
    recv_idle_en  = 1'b0;
    sink_hold_req = 1'b1;
    send_random_pixels(40);
  endtask

  // The sender stops until the block has emptied, then resumes mid-frame.
  task automatic test_sender_pause();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    send_random_pixels(12);
    wait_for_drain();
    send_random_pixels(12);
  endtask

  // Random frames: mostly small sizes so frames complete often, now and
  // then any 13-bit value, with the idling mode drawn per phase.
  task automatic test_random_frames();
    int total;
    int phase_items;
    int w, h;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      wait_for_drain();
      if ($urandom_range(7, 0) == 0) begin
        w = $urandom_range(8191, 0);
        h = $urandom_range(8191, 0);
      end else begin
        w = $urandom_range(12, 1);
        h = $urandom_range(12, 1);
      end
      set_frame_size(w, h);
      case ($urandom_range(3, 0))
        0: begin
          send_idle_en = 1'b0;
          recv_idle_en = 1'b0;
        end
        1: begin
          send_idle_en = 1'b1;
          recv_idle_en = 1'b0;
        end
        2: begin
          send_idle_en = 1'b0;
          recv_idle_en = 1'b1;
        end
        default: begin
          send_idle_en = 1'b1;
          recv_idle_en = 1'b1;
        end
      endcase
      phase_items = $urandom_range(120, 30);
      send_random_pixels(phase_items);
      total += phase_items;
    end
  endtask

  // --------------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus
    rst            <= 1'b1;
    cfg_wen        <= 1'b0;
    cfg_index      <= r2n_pkg::REG_FRAME_WIDTH;
    cfg_data       <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.blue  <= '0;
    pixel_ch.green <= '0;
    pixel_ch.red   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_color_extremes();
    test_size_saturation();
    test_resize_mid_frame();
    test_backpressure();
    test_sender_pause();
    test_random_frames();
    wait_for_drain();

    $display("Compared %0d pixel writes under %0d frame size settings.",
             checked_count, setting_count);
    $display("Reached %0d frame ends, with %0d field mismatches or stray results.",
             frame_count, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
